@@ rtl/lms_pkg.sv @@
package lms_pkg;

	localparam int FRAC_BITS = 32;
	localparam int WORD_W = 64;
	localparam int DIV_ITER = WORD_W + FRAC_BITS;
	localparam int SQ_ITER = (WORD_W + FRAC_BITS + 1) / 2;
	localparam int SQ_SH = FRAC_BITS + 2 * WORD_W - 2 * SQ_ITER;
	localparam int CNT_W = $clog2(DIV_ITER + 1);

	localparam logic signed [WORD_W-1:0] SMAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] SMIN = {1'b1, {(WORD_W-1){1'b0}}};

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_FIRST,
		PH_DESCEND,
		PH_NARROW
	} phase_t;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} arith_op_t;

	typedef struct packed {
		logic go;
		arith_op_t op;
	} arith_req_t;

	typedef enum logic [5:0] {
		S_IDLE,
		S_F1, S_F2, S_F3,
		S_D1, S_D2, S_D3,
		S_NP0, S_NP1, S_NP2,
		S_I0, S_I1, S_I1W, S_I2, S_I3, S_I3W, S_I4, S_I4W, S_I5, S_I5W,
		S_I6, S_I7, S_I8, S_I9, S_I9W, S_I10,
		S_SP0, S_SP1, S_SP2, S_SP2W, S_SP3, S_SP3W, S_SP4,
		S_CL0, S_CL1, S_CL2, S_CL3, S_CL4,
		S_EMIT
	} seq_state_t;

	function automatic logic signed [WORD_W-1:0] sadd(input logic signed [WORD_W-1:0] a,
			input logic signed [WORD_W-1:0] b);
		logic signed [WORD_W:0] s;
		s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1]) begin
			return s[WORD_W] ? SMIN : SMAX;
		end
		return s[WORD_W-1:0];
	endfunction

	function automatic logic signed [WORD_W-1:0] ssub(input logic signed [WORD_W-1:0] a,
			input logic signed [WORD_W-1:0] b);
		logic signed [WORD_W:0] s;
		s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1]) begin
			return s[WORD_W] ? SMIN : SMAX;
		end
		return s[WORD_W-1:0];
	endfunction

endpackage

@@ rtl/lms_arith.sv @@
module lms_arith (
	input  logic clk,
	input  logic arst_n,
	input  lms_pkg::arith_req_t req,
	input  logic signed [lms_pkg::WORD_W-1:0] a,
	input  logic signed [lms_pkg::WORD_W-1:0] b,
	output logic done,
	output logic signed [lms_pkg::WORD_W-1:0] result
);

	localparam int W = lms_pkg::WORD_W;
	localparam int F = lms_pkg::FRAC_BITS;

	logic busy_q;
	logic done_q;
	lms_pkg::arith_op_t op_q;
	logic [lms_pkg::CNT_W-1:0] cnt_q;
	logic [2*W-1:0] x_q;
	logic [W-1:0] y_q;
	logic [W-1:0] z_q;
	logic [W-1:0] q_q;
	logic flag_q;
	logic neg_q;
	logic signed [W-1:0] result_q;

	logic [W-1:0] mag_a;
	logic [W-1:0] mag_b;
	logic [W:0] mul_sum;
	logic [W:0] div_r2;
	logic div_ge;
	logic [W+1:0] sq_r2;
	logic [W+1:0] sq_trial;
	logic sq_ge;
	logic [W-1:0] fin_mag;
	logic [W-1:0] mul_mag;

	assign mag_a = a[W-1] ? (~a + 1'b1) : a;
	assign mag_b = b[W-1] ? (~b + 1'b1) : b;

	assign mul_sum = x_q[0] ? ({1'b0, x_q[2*W-1:W]} + {1'b0, y_q}) : {1'b0, x_q[2*W-1:W]};
	assign div_r2 = {z_q, x_q[2*W-1]};
	assign div_ge = div_r2 >= {1'b0, y_q};
	assign sq_r2 = {z_q, x_q[2*W-1:2*W-2]};
	assign sq_trial = {q_q, 2'b01};
	assign sq_ge = sq_r2 >= sq_trial;
	assign mul_mag = x_q[F+W-1:F];

	always_comb begin
		case (op_q)
			lms_pkg::OP_MUL: begin
				fin_mag = (|x_q[2*W-1:F+W-1]) ? lms_pkg::SMAX : mul_mag;
			end
			lms_pkg::OP_DIV: begin
				fin_mag = (flag_q || q_q[W-1]) ? lms_pkg::SMAX : q_q;
			end
			lms_pkg::OP_SQRT: begin
				fin_mag = flag_q ? '0 : q_q;
			end
			default: begin
				fin_mag = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q <= lms_pkg::OP_MUL;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				op_q <= req.op;
				case (req.op)
					lms_pkg::OP_MUL: cnt_q <= lms_pkg::CNT_W'(W);
					lms_pkg::OP_DIV: cnt_q <= lms_pkg::CNT_W'(lms_pkg::DIV_ITER);
					default: cnt_q <= lms_pkg::CNT_W'(lms_pkg::SQ_ITER);
				endcase
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			z_q <= '0;
			q_q <= '0;
			y_q <= mag_b;
			case (req.op)
				lms_pkg::OP_MUL: begin
					x_q <= {{W{1'b0}}, mag_a};
					neg_q <= a[W-1] ^ b[W-1];
					flag_q <= 1'b0;
				end
				lms_pkg::OP_DIV: begin
					x_q <= {mag_a, {W{1'b0}}};
					neg_q <= a[W-1] ^ b[W-1];
					flag_q <= 1'b0;
				end
				default: begin
					x_q <= {{W{1'b0}}, a} << lms_pkg::SQ_SH;
					neg_q <= 1'b0;
					flag_q <= a[W-1] || (a == '0);
				end
			endcase
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				result_q <= neg_q ? (~fin_mag + 1'b1) : fin_mag;
			end else begin
				case (op_q)
					lms_pkg::OP_MUL: begin
						x_q <= {mul_sum, x_q[W-1:1]};
					end
					lms_pkg::OP_DIV: begin
						x_q <= x_q << 1;
						z_q <= div_ge ? W'(div_r2 - {1'b0, y_q}) : div_r2[W-1:0];
						q_q <= {q_q[W-2:0], div_ge};
						flag_q <= flag_q | q_q[W-1];
					end
					default: begin
						x_q <= x_q << 2;
						z_q <= sq_ge ? W'(sq_r2 - sq_trial) : sq_r2[W-1:0];
						q_q <= {q_q[W-2:0], sq_ge};
					end
				endcase
			end
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

@@ rtl/line_minimizer_sequencer_unit.sv @@
// words by work: a begin word, a start value or a value while idle go straight to the output;
// first and improving descent words pass the F or D steps; a narrowing word takes longest (up to
// five multiplies, a divide and a square root, all on one shared shift-add unit)
// throughput: one word at a time; in_stall stays high until the result is registered,
// so a stalled output word adds its wait to the next word
// reset: asynchronous, clears the search state and loads the default registers
module line_minimizer_sequencer_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic action,
	input  logic signed [63:0] func_value,
	output logic out_valid,
	input  logic out_stall,
	output logic kind,
	output logic signed [63:0] point,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [63:0] cfg_data
);

	localparam logic [1:0] CFG_START = 2'd0;
	localparam logic [1:0] CFG_STEP = 2'd1;
	localparam logic [1:0] CFG_TOL = 2'd2;

	lms_pkg::seq_state_t state_q, state_d;
	lms_pkg::phase_t phase_q;

	logic signed [63:0] start_point_q, initial_step_q;
	logic [62:0] tolerance_q;
	logic signed [63:0] best_x_q, best_f_q, low_x_q, low_f_q, high_x_q, high_f_q, pending_x_q;
	logic [1:0] budget_q;
	logic used_split_q;
	logic signed [63:0] f_q, t_q, d1_q, d2_q, df1_q, df2_q, num_q, den_q, d_q;
	logic split_q, pos_q, flag_q;
	logic res_kind_q;
	logic signed [63:0] res_point_q;
	logic out_valid_q, kind_q;
	logic signed [63:0] point_q;

	logic accept;
	logic signed [63:0] tol_s, tol2, tol_half, bw, den_next;
	logic emit_go;

	lms_pkg::arith_req_t a_req;
	logic signed [63:0] a_a, a_b, a_res;
	logic a_done;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != lms_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign tol_s = {1'b0, tolerance_q};
	assign tol2 = tolerance_q[62] ? lms_pkg::SMAX : {tolerance_q, 1'b0};
	assign tol_half = {2'b00, tolerance_q[62:1]};
	assign bw = lms_pkg::ssub(high_x_q, low_x_q);
	assign den_next = lms_pkg::sadd(t_q, t_q);
	assign emit_go = (state_q == lms_pkg::S_EMIT) && (!out_valid_q || !out_stall);

	lms_arith u_arith (
		.clk(clk),
		.arst_n(arst_n),
		.req(a_req),
		.a(a_a),
		.b(a_b),
		.done(a_done),
		.result(a_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lms_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		a_req.go = 1'b0;
		a_req.op = lms_pkg::OP_MUL;
		a_a = d1_q;
		a_b = t_q;
		case (state_q)
			lms_pkg::S_IDLE: begin
				if (accept) begin
					if (!action) begin
						state_d = lms_pkg::S_EMIT;
					end else begin
						case (phase_q)
							lms_pkg::PH_FIRST: state_d = lms_pkg::S_F1;
							lms_pkg::PH_DESCEND: begin
								state_d = (func_value < best_f_q) ? lms_pkg::S_D1
									: lms_pkg::S_NP0;
							end
							lms_pkg::PH_NARROW: state_d = lms_pkg::S_NP0;
							default: state_d = lms_pkg::S_EMIT;
						endcase
					end
				end
			end
			lms_pkg::S_F1: state_d = lms_pkg::S_F2;
			lms_pkg::S_F2: state_d = lms_pkg::S_F3;
			lms_pkg::S_F3: state_d = lms_pkg::S_EMIT;
			lms_pkg::S_D1: state_d = lms_pkg::S_D2;
			lms_pkg::S_D2: state_d = lms_pkg::S_D3;
			lms_pkg::S_D3: state_d = lms_pkg::S_EMIT;
			lms_pkg::S_NP0: state_d = (bw <= tol2) ? lms_pkg::S_EMIT : lms_pkg::S_NP1;
			lms_pkg::S_NP1: state_d = lms_pkg::S_NP2;
			lms_pkg::S_NP2: state_d = (budget_q != 2'd0) ? lms_pkg::S_I0 : lms_pkg::S_SP0;
			lms_pkg::S_I0: state_d = lms_pkg::S_I1;
			lms_pkg::S_I1: begin
				a_req.go = 1'b1;
				a_a = d2_q;
				state_d = lms_pkg::S_I1W;
			end
			lms_pkg::S_I1W: if (a_done) state_d = lms_pkg::S_I2;
			lms_pkg::S_I2: state_d = lms_pkg::S_I3;
			lms_pkg::S_I3: begin
				a_req.go = 1'b1;
				state_d = lms_pkg::S_I3W;
			end
			lms_pkg::S_I3W: if (a_done) state_d = lms_pkg::S_I4;
			lms_pkg::S_I4: begin
				a_req.go = 1'b1;
				a_b = df2_q;
				state_d = lms_pkg::S_I4W;
			end
			lms_pkg::S_I4W: if (a_done) state_d = lms_pkg::S_I5;
			lms_pkg::S_I5: begin
				a_req.go = 1'b1;
				a_a = d2_q;
				a_b = df1_q;
				state_d = lms_pkg::S_I5W;
			end
			lms_pkg::S_I5W: if (a_done) state_d = lms_pkg::S_I6;
			lms_pkg::S_I6: state_d = lms_pkg::S_I7;
			lms_pkg::S_I7: state_d = lms_pkg::S_I8;
			lms_pkg::S_I8: state_d = (den_next == '0) ? lms_pkg::S_SP0 : lms_pkg::S_I9;
			lms_pkg::S_I9: begin
				a_req.go = 1'b1;
				a_req.op = lms_pkg::OP_DIV;
				a_a = num_q;
				a_b = den_q;
				state_d = lms_pkg::S_I9W;
			end
			lms_pkg::S_I9W: if (a_done) state_d = lms_pkg::S_I10;
			lms_pkg::S_I10: begin
				state_d = (d_q >= d1_q && d_q <= d2_q) ? lms_pkg::S_CL0 : lms_pkg::S_SP0;
			end
			lms_pkg::S_SP0: state_d = lms_pkg::S_SP1;
			lms_pkg::S_SP1: state_d = lms_pkg::S_SP2;
			lms_pkg::S_SP2: begin
				a_req.go = 1'b1;
				a_a = pos_q ? d1_q : d2_q;
				state_d = lms_pkg::S_SP2W;
			end
			lms_pkg::S_SP2W: if (a_done) state_d = lms_pkg::S_SP3;
			lms_pkg::S_SP3: begin
				a_req.go = 1'b1;
				a_req.op = lms_pkg::OP_SQRT;
				a_a = t_q;
				state_d = lms_pkg::S_SP3W;
			end
			lms_pkg::S_SP3W: if (a_done) state_d = lms_pkg::S_SP4;
			lms_pkg::S_SP4: state_d = lms_pkg::S_CL0;
			lms_pkg::S_CL0: state_d = lms_pkg::S_CL1;
			lms_pkg::S_CL1: state_d = lms_pkg::S_CL2;
			lms_pkg::S_CL2: state_d = flag_q ? lms_pkg::S_CL4 : lms_pkg::S_CL3;
			lms_pkg::S_CL3: state_d = lms_pkg::S_CL4;
			lms_pkg::S_CL4: state_d = lms_pkg::S_EMIT;
			lms_pkg::S_EMIT: if (emit_go) state_d = lms_pkg::S_IDLE;
			default: state_d = lms_pkg::S_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_point_q <= '0;
			initial_step_q <= 64'sd1 <<< lms_pkg::FRAC_BITS;
			tolerance_q <= 63'd42950;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START: start_point_q <= cfg_data;
				CFG_STEP: initial_step_q <= cfg_data;
				CFG_TOL: tolerance_q <= cfg_data[62:0];
				default: ;
			endcase
		end
	end

	// search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lms_pkg::PH_IDLE;
			best_x_q <= '0;
			best_f_q <= '0;
			low_x_q <= '0;
			low_f_q <= '0;
			high_x_q <= '0;
			high_f_q <= '0;
			pending_x_q <= '0;
			budget_q <= 2'd2;
			used_split_q <= 1'b0;
		end else begin
			case (state_q)
				lms_pkg::S_IDLE: begin
					if (accept && !action) begin
						phase_q <= lms_pkg::PH_START;
						budget_q <= 2'd2;
						used_split_q <= 1'b0;
						pending_x_q <= start_point_q;
					end else if (accept) begin
						case (phase_q)
							lms_pkg::PH_START: begin
								best_x_q <= pending_x_q;
								best_f_q <= func_value;
								pending_x_q <= lms_pkg::sadd(pending_x_q, initial_step_q);
								phase_q <= lms_pkg::PH_FIRST;
							end
							lms_pkg::PH_FIRST: begin
								if (best_f_q > func_value) begin
									low_x_q <= best_x_q;
									low_f_q <= best_f_q;
									best_x_q <= pending_x_q;
									best_f_q <= func_value;
								end else begin
									low_x_q <= pending_x_q;
									low_f_q <= func_value;
								end
								phase_q <= lms_pkg::PH_DESCEND;
							end
							lms_pkg::PH_DESCEND: begin
								if (!(func_value < best_f_q)) begin
									if (low_x_q > pending_x_q) begin
										high_x_q <= low_x_q;
										high_f_q <= low_f_q;
										low_x_q <= pending_x_q;
										low_f_q <= func_value;
									end else begin
										high_x_q <= pending_x_q;
										high_f_q <= func_value;
									end
								end
							end
							lms_pkg::PH_NARROW: begin
								if (func_value < best_f_q) begin
									if (pending_x_q < best_x_q) begin
										high_x_q <= best_x_q;
										high_f_q <= best_f_q;
									end else begin
										low_x_q <= best_x_q;
										low_f_q <= best_f_q;
									end
									best_x_q <= pending_x_q;
									best_f_q <= func_value;
									if (used_split_q) budget_q <= 2'd0;
								end else begin
									if (pending_x_q < best_x_q) begin
										low_x_q <= pending_x_q;
										low_f_q <= func_value;
									end else begin
										high_x_q <= pending_x_q;
										high_f_q <= func_value;
									end
									if (used_split_q) budget_q <= 2'd2;
									else if (budget_q == 2'd1) budget_q <= 2'd0;
								end
							end
							default: phase_q <= lms_pkg::PH_IDLE;
						endcase
					end
				end
				lms_pkg::S_F3: begin
					pending_x_q <= lms_pkg::sadd(best_x_q, t_q);
				end
				lms_pkg::S_D3: begin
					low_x_q <= best_x_q;
					low_f_q <= best_f_q;
					best_x_q <= pending_x_q;
					best_f_q <= f_q;
					pending_x_q <= lms_pkg::sadd(pending_x_q, t_q);
				end
				lms_pkg::S_NP0: begin
					if (bw <= tol2) phase_q <= lms_pkg::PH_IDLE;
				end
				lms_pkg::S_I8: begin
					budget_q <= budget_q - 2'd1;
				end
				lms_pkg::S_CL4: begin
					used_split_q <= split_q;
					pending_x_q <= lms_pkg::sadd(best_x_q, d_q);
					phase_q <= lms_pkg::PH_NARROW;
				end
				default: ;
			endcase
		end
	end

	// working registers and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			lms_pkg::S_IDLE: begin
				if (accept) begin
					f_q <= func_value;
					if (!action) begin
						res_kind_q <= 1'b0;
						res_point_q <= start_point_q;
					end else if (phase_q == lms_pkg::PH_START) begin
						res_kind_q <= 1'b0;
						res_point_q <= lms_pkg::sadd(pending_x_q, initial_step_q);
					end else begin
						res_kind_q <= 1'b1;
						res_point_q <= best_x_q;
					end
				end
			end
			lms_pkg::S_F1: t_q <= lms_pkg::ssub(best_x_q, low_x_q);
			lms_pkg::S_F2: t_q <= lms_pkg::sadd(t_q, t_q);
			lms_pkg::S_F3: begin
				res_kind_q <= 1'b0;
				res_point_q <= lms_pkg::sadd(best_x_q, t_q);
			end
			lms_pkg::S_D1: t_q <= lms_pkg::ssub(pending_x_q, best_x_q);
			lms_pkg::S_D2: t_q <= lms_pkg::sadd(t_q, t_q);
			lms_pkg::S_D3: begin
				res_kind_q <= 1'b0;
				res_point_q <= lms_pkg::sadd(pending_x_q, t_q);
			end
			lms_pkg::S_NP0: begin
				res_kind_q <= 1'b1;
				res_point_q <= best_x_q;
			end
			lms_pkg::S_NP1: d1_q <= lms_pkg::ssub(low_x_q, best_x_q);
			lms_pkg::S_NP2: begin
				d2_q <= lms_pkg::ssub(high_x_q, best_x_q);
				split_q <= 1'b1;
			end
			lms_pkg::S_I0: t_q <= lms_pkg::ssub(low_f_q, best_f_q);
			lms_pkg::S_I1W: if (a_done) df1_q <= a_res;
			lms_pkg::S_I2: t_q <= lms_pkg::ssub(high_f_q, best_f_q);
			lms_pkg::S_I3W: if (a_done) df2_q <= a_res;
			lms_pkg::S_I4W: if (a_done) num_q <= a_res;
			lms_pkg::S_I5W: if (a_done) t_q <= a_res;
			lms_pkg::S_I6: num_q <= lms_pkg::ssub(num_q, t_q);
			lms_pkg::S_I7: t_q <= lms_pkg::ssub(df2_q, df1_q);
			lms_pkg::S_I8: den_q <= den_next;
			lms_pkg::S_I9W: if (a_done) d_q <= a_res;
			lms_pkg::S_I10: split_q <= !(d_q >= d1_q && d_q <= d2_q);
			lms_pkg::S_SP0: pos_q <= lms_pkg::sadd(d2_q, d1_q) > 0;
			lms_pkg::S_SP1: begin
				t_q <= pos_q ? lms_pkg::ssub(d1_q, d2_q) : lms_pkg::ssub(d2_q, d1_q);
			end
			lms_pkg::S_SP2W: if (a_done) t_q <= a_res;
			lms_pkg::S_SP3W: if (a_done) t_q <= a_res;
			lms_pkg::S_SP4: begin
				d_q <= pos_q ? lms_pkg::sadd(d1_q, t_q) : lms_pkg::ssub(d2_q, t_q);
			end
			lms_pkg::S_CL0: begin
				if (d_q < tol_s && d_q > -tol_s) d_q <= d_q[63] ? -tol_half : tol_half;
			end
			lms_pkg::S_CL1: flag_q <= lms_pkg::ssub(d_q, d1_q) < tol_s;
			lms_pkg::S_CL2: begin
				if (flag_q) d_q <= lms_pkg::sadd(d1_q, tol_s);
				else flag_q <= lms_pkg::ssub(d2_q, d_q) < tol_s;
			end
			lms_pkg::S_CL3: if (flag_q) d_q <= lms_pkg::ssub(d2_q, tol_s);
			lms_pkg::S_CL4: begin
				res_kind_q <= 1'b0;
				res_point_q <= lms_pkg::sadd(best_x_q, d_q);
			end
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			kind_q <= res_kind_q;
			point_q <= res_point_q;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign point = point_q;

`ifndef SYNTHESIS
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lms_pkg::S_EMIT && !out_valid_q |=> out_valid_q)
		else $error("pending word not moved to output");

	a_begin_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !action |=> state_q == lms_pkg::S_EMIT && phase_q == lms_pkg::PH_START
			&& !res_kind_q)
		else $error("begin word did not restart search");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		a_done |-> state_q == lms_pkg::S_I1W || state_q == lms_pkg::S_I3W
			|| state_q == lms_pkg::S_I4W || state_q == lms_pkg::S_I5W
			|| state_q == lms_pkg::S_I9W || state_q == lms_pkg::S_SP2W
			|| state_q == lms_pkg::S_SP3W)
		else $error("arith result outside wait state");

	a_idle_report: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action && phase_q == lms_pkg::PH_IDLE |=> res_kind_q
			&& res_point_q == $past(best_x_q))
		else $error("idle value did not report best point");
`endif

endmodule
